/* hw/rtl/pcomp_pkg.sv */
`timescale 1ns / 1ps

package pcomp_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP_CALIB    = 2'd0;
  localparam logic [1:0] CFG_PRESS_CALIB_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_CALIB_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_CALIB_C = 2'd3;

  localparam int unsigned DIV_STAGES    = 64;
  // start to done_o, in clock edges as seen at the ports
  localparam int unsigned PCOMP_LATENCY = 79;

  localparam logic signed [25:0] TFINE_OFFSET  = 26'sd128000;
  localparam logic [20:0]        PRESS_FULL    = 21'd1048576;
  localparam logic [12:0]        PRESS_SCALE   = 13'd3125;
  localparam logic [63:0]        PRESS_V1_BIAS = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [15:0] temp;
    logic        neg;
    logic        dz;
  } pcomp_side_t;

endpackage

/* hw/rtl/pcomp_div.sv */
`timescale 1ns / 1ps

// Unsigned 64 / 31 restoring divider, one quotient bit per stage.
module pcomp_div
  import pcomp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [63:0] num_i,
  input  logic [30:0] den_i,
  input  pcomp_side_t side_i,
  output logic        out_valid_o,
  output logic [63:0] quo_o,
  output pcomp_side_t side_o
);

  logic        vld_q  [DIV_STAGES];
  logic [63:0] quo_q  [DIV_STAGES];
  logic [30:0] rem_q  [DIV_STAGES];
  logic [30:0] den_q  [DIV_STAGES];
  pcomp_side_t side_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic        v_in;
    logic [63:0] quo_in;
    logic [30:0] rem_in;
    logic [30:0] den_in;
    pcomp_side_t side_in;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign quo_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // dividend bits shift out of the top of quo while quotient bits enter below
    assign trial = {rem_in, quo_in[63]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? diff[30:0] : trial[30:0];
      quo_q[i]  <= {quo_in[62:0], ge};
      den_q[i]  <= den_in;
      side_q[i] <= side_in;
    end
  end

  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign quo_o       = quo_q[DIV_STAGES-1];
  assign side_o      = side_q[DIV_STAGES-1];

endmodule

/* hw/rtl/pressure_temperature_compensation.sv */
`timescale 1ns / 1ps

// Channel  | Ports                                          | Transfer
// ---------+------------------------------------------------+-------------------------
// input    | start, busy, raw_temperature_i, raw_pressure_i | start && !busy
// result   | done_o, temperature_centi_o, pressure_q24_8_o, | done_o, one cycle
//          | divide_by_zero_o                               |
// config   | cfg_we_i, cfg_idx_i, cfg_data_i                | cfg_we_i
//
// One transaction per cycle; busy stays low. Each result passes through ten
// arithmetic stages, a 64-stage divider (one quotient bit per stage) and
// five stages after it.
// Reset clears all valid bits; calibration registers reset to zero.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module pressure_temperature_compensation
  import pcomp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  output logic               done_o,
  output logic signed [15:0] temperature_centi_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               divide_by_zero_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [15:0] press_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_a_q    <= '0;
      press_b_q    <= '0;
      press_c_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP_CALIB:    temp_calib_q <= cfg_data_i[47:0];
        CFG_PRESS_CALIB_A: press_a_q    <= cfg_data_i;
        CFG_PRESS_CALIB_B: press_b_q    <= cfg_data_i;
        CFG_PRESS_CALIB_C: press_c_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib_q[15:0];
  assign t2 = $signed(temp_calib_q[31:16]);
  assign t3 = $signed(temp_calib_q[47:32]);
  assign p1 = press_a_q[15:0];
  assign p2 = $signed(press_a_q[31:16]);
  assign p3 = $signed(press_a_q[47:32]);
  assign p4 = $signed(press_a_q[63:48]);
  assign p5 = $signed(press_b_q[15:0]);
  assign p6 = $signed(press_b_q[31:16]);
  assign p7 = $signed(press_b_q[47:32]);
  assign p8 = $signed(press_b_q[63:48]);
  assign p9 = $signed(press_c_q);

  assign busy = 1'b0;

  logic [9:0]  vld_q;
  logic [19:0] rawp_q [7];
  logic [15:0] tcar_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[8:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    rawp_q[0] <= raw_pressure_i;
    for (int k = 1; k < 7; k++) begin
      rawp_q[k] <= rawp_q[k-1];
    end
  end

  // stage 1: temperature differences and their products
  logic signed [17:0] a_c;
  logic signed [16:0] b_c;
  logic signed [33:0] bb_c;
  logic signed [33:0] pa_d, pa_q;
  logic [31:0]        bb_q;

  always_comb begin
    a_c  = $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, t1, 1'b0});
    b_c  = $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, t1});
    pa_d = a_c * t2;
    bb_c = b_c * b_c;
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    bb_q <= bb_c[31:0];
  end

  // stage 2
  logic signed [33:0] pa_sh;
  logic signed [22:0] v1t_q;
  logic signed [36:0] m3_d, m3_q;

  always_comb begin
    pa_sh = pa_q >>> 11;
    m3_d  = $signed({1'b0, bb_q[31:12]}) * t3;
  end

  always_ff @(posedge clk_i) begin
    v1t_q <= pa_sh[22:0];
    m3_q  <= m3_d;
  end

  // stage 3: fine temperature
  logic signed [36:0] m3_sh;
  logic signed [24:0] tf_d, tf_q;

  always_comb begin
    m3_sh = m3_q >>> 14;
    tf_d  = 25'(v1t_q) + 25'($signed(m3_sh[23:0]));
  end

  always_ff @(posedge clk_i) begin
    tf_q <= tf_d;
  end

  // stage 4: temperature output and pressure offset
  logic signed [28:0] t5_c, tsh_c;
  logic [15:0]        temp_d;
  logic signed [25:0] pv1_d, pv1_q;

  always_comb begin
    t5_c  = 29'(tf_q) * 29'sd5 + 29'sd128;
    tsh_c = t5_c >>> 8;
    if (tsh_c > 29'sd32767) begin
      temp_d = 16'h7fff;
    end else if (tsh_c < -29'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = tsh_c[15:0];
    end
    pv1_d = 26'(tf_q) - TFINE_OFFSET;
  end

  always_ff @(posedge clk_i) begin
    pv1_q     <= pv1_d;
    tcar_q[0] <= temp_d;
    for (int k = 1; k < 6; k++) begin
      tcar_q[k] <= tcar_q[k-1];
    end
  end

  // stage 5
  logic signed [51:0] sq_q;
  logic signed [41:0] m5_q, m2_q;

  always_ff @(posedge clk_i) begin
    sq_q <= pv1_q * pv1_q;
    m5_q <= pv1_q * p5;
    m2_q <= pv1_q * p2;
  end

  // stage 6
  logic signed [67:0] sq6_c, sq3_c;
  logic [63:0]        sq6_q, sq3_q;
  logic signed [41:0] m5b_q, m2b_q;

  always_comb begin
    sq6_c = sq_q * p6;
    sq3_c = sq_q * p3;
  end

  always_ff @(posedge clk_i) begin
    sq6_q <= sq6_c[63:0];
    sq3_q <= sq3_c[63:0];
    m5b_q <= m5_q;
    m2b_q <= m2_q;
  end

  // stage 7
  logic [63:0] v2_d, v2_q, v1a_d, v1a_q;

  always_comb begin
    v2_d  = sq6_q + (64'(m5b_q) << 17) + (64'(p4) << 35);
    v1a_d = 64'($signed(sq3_q) >>> 8) + (64'(m2b_q) << 12);
  end

  always_ff @(posedge clk_i) begin
    v2_q  <= v2_d;
    v1a_q <= v1a_d;
  end

  // stage 8: divisor and numerator base
  logic signed [80:0] pr_c;
  logic [20:0]        pp_c;
  logic signed [30:0] v1d_q;
  logic [63:0]        npre_d, npre_q;

  always_comb begin
    pr_c   = $signed(v1a_q + PRESS_V1_BIAS) * $signed({1'b0, p1});
    pp_c   = PRESS_FULL - {1'b0, rawp_q[6]};
    npre_d = ({43'd0, pp_c} << 31) - v2_q;
  end

  always_ff @(posedge clk_i) begin
    v1d_q  <= $signed(pr_c[63:33]);
    npre_q <= npre_d;
  end

  // stage 9
  logic [76:0]        np_c;
  logic [63:0]        num_q;
  logic signed [30:0] v1e_q;

  assign np_c = npre_q * PRESS_SCALE;

  always_ff @(posedge clk_i) begin
    num_q <= np_c[63:0];
    v1e_q <= v1d_q;
  end

  // stage 10: magnitudes for the divider
  logic [63:0] mn_q;
  logic [30:0] md_q;
  pcomp_side_t side_d, side_q;

  always_comb begin
    side_d.temp = tcar_q[5];
    side_d.neg  = num_q[63] ^ v1e_q[30];
    side_d.dz   = (v1e_q == '0);
  end

  always_ff @(posedge clk_i) begin
    mn_q   <= num_q[63] ? 64'(64'd0 - num_q) : num_q;
    md_q   <= v1e_q[30] ? 31'(31'd0 - v1e_q) : v1e_q;
    side_q <= side_d;
  end

  logic        dv_valid;
  logic [63:0] dv_quo;
  pcomp_side_t dv_side;

  pcomp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[9]),
    .num_i       (mn_q),
    .den_i       (md_q),
    .side_i      (side_q),
    .out_valid_o (dv_valid),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  // post-divide stages
  logic        vD_q, vE_q, vF_q, vG_q;
  pcomp_side_t sD_q, sE_q, sF_q, sG_q;
  logic [63:0] pD_q, pE_q, pF_q, pG_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vD_q   <= 1'b0;
      vE_q   <= 1'b0;
      vF_q   <= 1'b0;
      vG_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vD_q   <= dv_valid;
      vE_q   <= vD_q;
      vF_q   <= vE_q;
      vG_q   <= vF_q;
      done_o <= vG_q;
    end
  end

  // stage D: restore the quotient sign
  always_ff @(posedge clk_i) begin
    pD_q <= dv_side.neg ? 64'(64'd0 - dv_quo) : dv_quo;
    sD_q <= dv_side;
  end

  // stage E: square of p >>> 13 as 32-bit partial products, and p * P8
  logic signed [63:0] x_c;
  logic [63:0]        ll_c, hl_c;
  logic signed [79:0] pp8_c;
  logic [63:0]        ll_q, pp8_q;
  logic [31:0]        hl_q;

  always_comb begin
    x_c   = $signed(pD_q) >>> 13;
    ll_c  = x_c[31:0] * x_c[31:0];
    hl_c  = x_c[63:32] * x_c[31:0];
    pp8_c = $signed(pD_q) * p8;
  end

  always_ff @(posedge clk_i) begin
    ll_q  <= ll_c;
    hl_q  <= hl_c[31:0];
    pp8_q <= pp8_c[63:0];
    pE_q  <= pD_q;
    sE_q  <= sD_q;
  end

  // stage F
  logic [63:0] xx_q, v2b_q;

  always_ff @(posedge clk_i) begin
    xx_q  <= ll_q + {hl_q[30:0], 33'd0};
    v2b_q <= 64'($signed(pp8_q) >>> 19);
    pF_q  <= pE_q;
    sF_q  <= sE_q;
  end

  // stage G
  logic signed [79:0] px_c;
  logic [63:0]        v1b_q, v2c_q;

  assign px_c = $signed(xx_q) * p9;

  always_ff @(posedge clk_i) begin
    v1b_q <= 64'($signed(px_c[63:0]) >>> 25);
    v2c_q <= v2b_q;
    pG_q  <= pF_q;
    sG_q  <= sF_q;
  end

  // output stage: final sum and saturation
  logic [63:0] sum_c, fin_c;
  logic [31:0] press_d;

  always_comb begin
    sum_c = pG_q + v1b_q + v2c_q;
    fin_c = 64'($signed(sum_c) >>> 8) + (64'(p7) << 4);
    if (sG_q.dz || fin_c[63]) begin
      press_d = '0;
    end else if (fin_c[63:32] != '0) begin
      press_d = 32'hffff_ffff;
    end else begin
      press_d = fin_c[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    temperature_centi_o <= $signed(sG_q.temp);
    pressure_q24_8_o    <= press_d;
    divide_by_zero_o    <= sG_q.dz & vG_q;
  end

endmodule

/* hw/rtl/pcomp_checker.sv */
`timescale 1ns / 1ps

module pcomp_checker
  import pcomp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] pressure_q24_8_o,
  input logic        divide_by_zero_o
);

  // every result traces back to a transaction a fixed number of cycles earlier
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PCOMP_LATENCY))
    else $error("result without matching start");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divide_by_zero_o |-> (done_o && pressure_q24_8_o == '0))
    else $error("zero divisor flag with nonzero pressure or no result");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("pipeline refused a transaction");

endmodule

bind pressure_temperature_compensation pcomp_checker u_pcomp_checker (.*);

/* verif/pressure_temperature_compensation_tb.sv */
`timescale 1ns / 1ps

module pressure_temperature_compensation_tb;
  import pcomp_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic               dz;
  } comp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        done_o;
  logic signed [15:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic        divide_by_zero_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_TEMP_CALIB;
  logic [63:0] cfg_data_i = '0;

  pressure_temperature_compensation u_dut (
    .clk_i, .rst_ni, .start, .busy, .raw_temperature_i, .raw_pressure_i,
    .done_o, .temperature_centi_o, .pressure_q24_8_o, .divide_by_zero_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of the calibration words
  logic [47:0] temp_cal;
  logic [63:0] press_cal_a, press_cal_b;
  logic [15:0] press_cal_c;

  comp_result_t pending_results[$];
  int unsigned  error_count;
  int unsigned  idle_cycles;
  logic         finished;

  function automatic logic signed [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, v1, v2, tf, t, p, num;
    logic [63:0] mn, md, q;
    comp_result_t r;
    t1 = {48'd0, temp_cal[15:0]};
    t2 = sx16(temp_cal[31:16]);
    t3 = sx16(temp_cal[47:32]);
    p1 = {48'd0, press_cal_a[15:0]};
    p2 = sx16(press_cal_a[31:16]);
    p3 = sx16(press_cal_a[47:32]);
    p4 = sx16(press_cal_a[63:48]);
    p5 = sx16(press_cal_b[15:0]);
    p6 = sx16(press_cal_b[31:16]);
    p7 = sx16(press_cal_b[47:32]);
    p8 = sx16(press_cal_b[63:48]);
    p9 = sx16(press_cal_c);

    a = $signed({44'd0, adc_t} >> 3) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    b = $signed({44'd0, adc_t} >> 4) - t1;
    v2 = (((b * b) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    t = (tf * 5 + 128) >>> 8;
    if (t < -32768) t = -32768;
    else if (t > 32767) t = 32767;
    r.temp = t[15:0];

    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press = '0;
      r.dz = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, adc_p});
      num = ((p <<< 31) - v2) * 3125;
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      q = mn / md;
      p = (num[63] != v1[63]) ? -q : q;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sh0FFFFFFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
      r.dz = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    comp_result_t want;
    if (rst_ni && !finished) begin
      idle_cycles <= (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (temperature_centi_o !== want.temp)
            report_mismatch("temperature", 64'(temperature_centi_o), 64'(want.temp));
          if (pressure_q24_8_o !== want.press)
            report_mismatch("pressure", 64'(pressure_q24_8_o), 64'(want.press));
          if (divide_by_zero_o !== want.dz)
            report_mismatch("divide_by_zero", 64'(divide_by_zero_o), 64'(want.dz));
        end
      end
      if (idle_cycles > 2000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  int burst_left;

  task automatic send_sample(logic [19:0] adc_t, logic [19:0] adc_p);
    // random bursts with gaps between them
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    raw_temperature_i <= adc_t;
    raw_pressure_i <= adc_p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(compensate(adc_t, adc_p));
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (PCOMP_LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEMP_CALIB:    temp_cal = data[47:0];
      CFG_PRESS_CALIB_A: press_cal_a = data;
      CFG_PRESS_CALIB_B: press_cal_b = data;
      CFG_PRESS_CALIB_C: press_cal_c = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // datasheet-like calibration so that pressure lands in a sensible range
  task automatic load_typical_calib();
    write_cfg(CFG_TEMP_CALIB, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_cfg(CFG_PRESS_CALIB_A, {16'd2855, 16'd3024, -16'sd10685, 16'd36477});
    write_cfg(CFG_PRESS_CALIB_B, {-16'sd7, 16'd15500, -16'sd14600, 16'd140});
    write_cfg(CFG_PRESS_CALIB_C, 64'd6000);
  endtask

  task automatic test_reset_calib();
    // all-zero calibration: divisor is zero
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  task automatic test_directed();
    logic [19:0] ext[4] = '{20'd0, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    load_typical_calib();
    foreach (ext[i]) foreach (ext[j]) send_sample(ext[i], ext[j]);
    send_sample(20'd519888, 20'd415148);
    drain();
    // extreme calibration words, temperature saturates high
    write_cfg(CFG_TEMP_CALIB, {16'h7FFF, 16'h7FFF, 16'd0});
    write_cfg(CFG_PRESS_CALIB_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_PRESS_CALIB_B, 64'h8000_8000_8000_8000);
    write_cfg(CFG_PRESS_CALIB_C, 64'h8000);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd0, 20'hFFFFF);
    drain();
    write_cfg(CFG_TEMP_CALIB, {16'h8000, 16'h8000, 16'hFFFF});
    write_cfg(CFG_PRESS_CALIB_B, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cfg(CFG_PRESS_CALIB_C, 64'h7FFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'd0);
    drain();
  endtask

  task automatic test_random(int n_phases, int per_phase);
    for (int ph = 0; ph < n_phases; ph++) begin
      case (ph % 3)
        0: load_typical_calib();
        1: begin
          write_cfg(CFG_TEMP_CALIB, rand64());
          write_cfg(CFG_PRESS_CALIB_A, rand64());
          write_cfg(CFG_PRESS_CALIB_B, rand64());
          write_cfg(CFG_PRESS_CALIB_C, rand64());
        end
        default: begin
          // perturb typical values: low bits of p8, random p9
          load_typical_calib();
          write_cfg(CFG_PRESS_CALIB_B,
                    press_cal_b ^ {16'($urandom_range(0, 255)), 48'd0});
          write_cfg(CFG_PRESS_CALIB_C, 64'($urandom_range(0, 65535)));
        end
      endcase
      for (int k = 0; k < per_phase; k++)
        if ($urandom_range(0, 3) == 0)
          send_sample(20'($urandom_range(0, 20'hFFFFF)),
                      20'($urandom_range(0, 20'hFFFFF)));
        else
          send_sample(20'($urandom_range(400000, 600000)),
                      20'($urandom_range(250000, 500000)));
      drain();
    end
  endtask

  initial begin
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    error_count = 0;
    idle_cycles = 0;
    finished = 1'b0;
    burst_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_calib();
    test_directed();
    test_random(11, 100);
    finished = 1'b1;
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
